// ===== src/c2csr_pkg.sv =====
package c2csr_pkg;

  // Store sizes
  localparam int MaxRows    = 1024;
  localparam int MaxEntries = 4096;
  localparam int ColLimit   = 1024;

  // Field widths
  localparam int ModeW  = 3;
  localparam int RowW   = 10;
  localparam int ColW   = 10;
  localparam int IdxW   = 12;
  localparam int CntW   = 13;
  localparam int CfgW   = 11;
  localparam int SDataW = 32;
  localparam int MDataW = 32;

  // Memory address widths
  localparam int PtrAw = $clog2(MaxRows + 1);
  localparam int CurAw = $clog2(MaxRows);
  localparam int EntAw = $clog2(MaxEntries);

  // Input tdata layout, lowest field first
  localparam int RowLsb = 0;
  localparam int ColLsb = RowLsb + RowW;
  localparam int IdxLsb = ColLsb + ColW;

  localparam logic [CfgW-1:0] RowMax   = CfgW'(MaxRows);
  localparam logic [CfgW-1:0] ColMax   = CfgW'(ColLimit);
  localparam logic [CntW-1:0] CountMax = CntW'(MaxEntries);

  typedef enum logic [ModeW-1:0] {
    MODE_ADD    = 3'd0,
    MODE_BUILD  = 3'd1,
    MODE_RD_PTR = 3'd2,
    MODE_RD_COL = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_READ = 2'd3
  } status_e;

  typedef enum logic {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_B_CLR,
    ST_CNT_A,
    ST_CNT_B,
    ST_CNT_C,
    ST_PFX_A,
    ST_PFX_B,
    ST_SCT_A,
    ST_SCT_B,
    ST_SCT_C,
    ST_DONE
  } state_e;

  // Result word, value in the lowest bits
  typedef struct packed {
    logic            error_seen;
    logic [CntW-1:0] entry_count;
    status_e         status;
    logic [CntW-1:0] value;
  } result_t;

  localparam int ResW = $bits(result_t);

endpackage

// ===== src/c2csr_ram.sv =====
module c2csr_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry into a held output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/coo_to_csr_builder.sv =====
// Channel   | Direction | Signals                                  | Contents
// s_axis    | in        | tvalid tready tdata[31:0] tuser[2:0]     | coordinate or command
// m_axis    | out       | tvalid tready tdata[31:0]                | one result per request
// cfg       | in        | cfg_valid_i cfg_ready_o cfg_index_i      | row/column count writes
//           |           | cfg_data_i[10:0]                         |
//
// Add, clear, unused modes and failing reads finish in the accept cycle; good reads
// load their result in ST_RD from the registered RAM read. Build runs a zeroing
// sweep of the pointer RAM, then count, prefix and scatter passes, each paced by the
// registered reads of the coordinate, pointer and cursor RAMs and one shared 13-bit adder.
// Reset clears the entry count, the flags and sets both counts to 1024; the
// coordinate, pointer, cursor and column RAMs are not cleared.
// A result waits in the output register; no request is taken until it can move.
module coo_to_csr_builder
  import c2csr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,   // row[9:0], col[19:10], index[31:20]
  input  logic [ModeW-1:0]  s_axis_tuser,   // mode[2:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MDataW-1:0] m_axis_tdata,   // value[12:0], status[14:13],
                                            // entry_count[27:15], error_seen[28], zero[31:29]
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  // Request fields
  logic [RowW-1:0] in_row;
  logic [ColW-1:0] in_col;
  logic [IdxW-1:0] in_idx;
  mode_e           in_mode;

  assign in_row  = s_axis_tdata[RowLsb +: RowW];
  assign in_col  = s_axis_tdata[ColLsb +: ColW];
  assign in_idx  = s_axis_tdata[IdxLsb +: IdxW];
  assign in_mode = mode_e'(s_axis_tuser);

  // Control state
  state_e           state_q, state_d;
  logic [CntW-1:0]  acc_q, acc_d;
  logic             reject_q, reject_d;
  logic             built_q, built_d;
  logic [CfgW-1:0]  row_count_q, col_count_q;
  logic [EntAw-1:0] t_q, t_d;
  logic [PtrAw-1:0] a_q, a_d;
  logic [CntW-1:0]  sum_q, sum_d;
  logic             rd_col_q, rd_col_d;
  logic             m_valid_q, m_valid_d;
  result_t          m_res_q, m_res_d;

  // RAM ports
  logic             crd_we, crd_re;
  logic [RowW+ColW-1:0] crd_wdata, crd_rdata;
  logic             ptr_we, ptr_re;
  logic [PtrAw-1:0] ptr_waddr, ptr_raddr;
  logic [CntW-1:0]  ptr_wdata, ptr_rdata;
  logic             cur_we, cur_re;
  logic [CurAw-1:0] cur_waddr;
  logic [CntW-1:0]  cur_wdata, cur_rdata;
  logic             cid_we, cid_re;
  logic [ColW-1:0]  cid_rdata;

  // Shared adder
  logic [CntW-1:0]  add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  // Misc derived values
  logic [CfgW-1:0]  eff_rows, eff_cols;
  logic [RowW-1:0]  crd_row;
  logic [ColW-1:0]  crd_col;
  logic [PtrAw-1:0] row_plus, a_inc;
  logic             last_t, out_free, m_load;
  status_e          res_stat;
  logic [CntW-1:0]  res_val;

  assign eff_rows = (row_count_q > RowMax) ? RowMax : row_count_q;
  assign eff_cols = (col_count_q > ColMax) ? ColMax : col_count_q;
  assign crd_row  = crd_rdata[RowW-1:0];
  assign crd_col  = crd_rdata[RowW +: ColW];
  assign row_plus = PtrAw'(crd_row) + PtrAw'(1);
  assign a_inc    = a_q + PtrAw'(1);
  assign last_t   = (CntW'(t_q) + CntW'(1)) == acc_q;
  assign out_free = !m_valid_q || m_axis_tready;
  assign crd_wdata = {in_col, in_row};

  // Sequencer: next state, RAM controls and result
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    reject_d  = reject_q;
    built_d   = built_q;
    t_d       = t_q;
    a_d       = a_q;
    sum_d     = sum_q;
    rd_col_d  = rd_col_q;
    crd_we    = 1'b0;
    crd_re    = 1'b0;
    ptr_we    = 1'b0;
    ptr_re    = 1'b0;
    ptr_waddr = a_q;
    ptr_raddr = a_inc;
    ptr_wdata = add_sum;
    cur_we    = 1'b0;
    cur_re    = 1'b0;
    cur_waddr = crd_row;
    cur_wdata = add_sum;
    cid_we    = 1'b0;
    cid_re    = 1'b0;
    add_a     = acc_q;
    add_b     = CntW'(1);
    m_load    = 1'b0;
    res_stat  = STAT_OK;
    res_val   = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          case (in_mode)
            MODE_ADD: begin
              m_load = 1'b1;
              if (CfgW'(in_row) >= eff_rows || CfgW'(in_col) >= eff_cols) begin
                res_stat = STAT_RANGE;
                reject_d = 1'b1;
              end else if (acc_q == CountMax) begin
                res_stat = STAT_FULL;
              end else begin
                crd_we  = 1'b1;
                acc_d   = add_sum;
                built_d = 1'b0;
              end
            end
            MODE_BUILD: begin
              a_d     = '0;
              state_d = ST_B_CLR;
            end
            MODE_RD_PTR: begin
              if (built_q && in_idx <= IdxW'(eff_rows)) begin
                ptr_re    = 1'b1;
                ptr_raddr = in_idx[PtrAw-1:0];
                rd_col_d  = 1'b0;
                state_d   = ST_RD;
              end else begin
                m_load   = 1'b1;
                res_stat = STAT_BAD_READ;
              end
            end
            MODE_RD_COL: begin
              if (built_q && CntW'(in_idx) < acc_q) begin
                cid_re   = 1'b1;
                rd_col_d = 1'b1;
                state_d  = ST_RD;
              end else begin
                m_load   = 1'b1;
                res_stat = STAT_BAD_READ;
              end
            end
            MODE_CLEAR: begin
              m_load   = 1'b1;
              acc_d    = '0;
              reject_d = 1'b0;
              built_d  = 1'b0;
            end
            default: begin
              m_load = 1'b1;
            end
          endcase
        end
      end

      // Hand out the read data once the output register is free
      ST_RD: begin
        if (out_free) begin
          m_load  = 1'b1;
          res_val = rd_col_q ? CntW'(cid_rdata) : ptr_rdata;
          state_d = ST_IDLE;
        end
      end

      // Zero all row counts
      ST_B_CLR: begin
        ptr_we    = 1'b1;
        ptr_wdata = '0;
        if (a_q == PtrAw'(MaxRows)) begin
          t_d   = '0;
          a_d   = '0;
          sum_d = '0;
          state_d = (acc_q == '0) ? ST_PFX_A : ST_CNT_A;
        end else begin
          a_d = a_inc;
        end
      end

      // Count pass: fetch entry, fetch its row count, bump it
      ST_CNT_A: begin
        crd_re  = 1'b1;
        state_d = ST_CNT_B;
      end
      ST_CNT_B: begin
        ptr_re    = 1'b1;
        ptr_raddr = row_plus;
        state_d   = ST_CNT_C;
      end
      ST_CNT_C: begin
        add_a     = ptr_rdata;
        ptr_we    = 1'b1;
        ptr_waddr = row_plus;
        if (last_t) begin
          state_d = ST_PFX_A;
        end else begin
          t_d     = t_q + EntAw'(1);
          state_d = ST_CNT_A;
        end
      end

      // Prefix pass: the running sum is each row's start and first cursor
      ST_PFX_A: begin
        ptr_re    = 1'b1;
        cur_we    = 1'b1;
        cur_waddr = a_q[CurAw-1:0];
        cur_wdata = sum_q;
        state_d   = ST_PFX_B;
      end
      ST_PFX_B: begin
        add_a     = sum_q;
        add_b     = ptr_rdata;
        ptr_we    = 1'b1;
        ptr_waddr = a_inc;
        sum_d     = add_sum;
        if (a_q == PtrAw'(MaxRows - 1)) begin
          t_d     = '0;
          state_d = (acc_q == '0) ? ST_DONE : ST_SCT_A;
        end else begin
          a_d     = a_inc;
          state_d = ST_PFX_A;
        end
      end

      // Scatter pass: place each column at its row cursor, advance the cursor
      ST_SCT_A: begin
        crd_re  = 1'b1;
        state_d = ST_SCT_B;
      end
      ST_SCT_B: begin
        cur_re  = 1'b1;
        state_d = ST_SCT_C;
      end
      ST_SCT_C: begin
        add_a  = cur_rdata;
        cid_we = 1'b1;
        cur_we = 1'b1;
        if (last_t) begin
          state_d = ST_DONE;
        end else begin
          t_d     = t_q + EntAw'(1);
          state_d = ST_SCT_A;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          m_load  = 1'b1;
          built_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register
    m_valid_d = m_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
    m_res_d   = m_res_q;
    if (m_load) begin
      m_res_d.value       = res_val;
      m_res_d.status      = res_stat;
      m_res_d.entry_count = acc_d;
      m_res_d.error_seen  = reject_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      reject_q    <= 1'b0;
      built_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      row_count_q <= RowMax;
      col_count_q <= ColMax;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      reject_q  <= reject_d;
      built_q   <= built_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ROW_COUNT:    row_count_q <= cfg_data_i;
          CFG_COLUMN_COUNT: col_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    a_q      <= a_d;
    sum_q    <= sum_d;
    rd_col_q <= rd_col_d;
    m_res_q  <= m_res_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = MDataW'(m_res_q);

  // Stored coordinates, column above row
  c2csr_ram #(
    .Width (RowW + ColW),
    .Depth (MaxEntries)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (crd_we),
    .waddr_i (acc_q[EntAw-1:0]),
    .wdata_i (crd_wdata),
    .re_i    (crd_re),
    .raddr_i (t_q),
    .rdata_o (crd_rdata)
  );

  // Row counts, then row pointers
  c2csr_ram #(
    .Width (CntW),
    .Depth (MaxRows + 1)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .re_i    (ptr_re),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  // Per-row scatter cursors
  c2csr_ram #(
    .Width (CntW),
    .Depth (MaxRows)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .re_i    (cur_re),
    .raddr_i (crd_row),
    .rdata_o (cur_rdata)
  );

  // Column indices in row order
  c2csr_ram #(
    .Width (ColW),
    .Depth (MaxEntries)
  ) u_cidx_ram (
    .clk_i   (clk_i),
    .we_i    (cid_we),
    .waddr_i (cur_rdata[EntAw-1:0]),
    .wdata_i (crd_col),
    .re_i    (cid_re),
    .raddr_i (in_idx[EntAw-1:0]),
    .rdata_o (cid_rdata)
  );

endmodule

// ===== src/c2csr_checker.sv =====
module c2csr_checker
  import c2csr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [SDataW-1:0] s_axis_tdata,
  input logic [ModeW-1:0]  s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              cfg_index_i,
  input logic [CfgW-1:0]   cfg_data_i
);

  result_t res;
  assign res = result_t'(m_axis_tdata[ResW-1:0]);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Entry count never passes the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.entry_count <= CountMax)
    else $error("entry count beyond store size");

  // A rejected coordinate leaves the sticky flag set
  a_range_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == STAT_RANGE |-> res.error_seen)
    else $error("range error without sticky flag");

  // Full status only with a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == STAT_FULL |-> res.entry_count == CountMax)
    else $error("store full reported below capacity");

  // Nonzero data only on a good read
  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.value != '0 |-> res.status == STAT_OK)
    else $error("data returned with a failing status");

endmodule

bind coo_to_csr_builder c2csr_checker u_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import c2csr_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int RandItems = 700;
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd5;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata = '0;
  logic [ModeW-1:0]  s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MDataW-1:0] m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  coo_to_csr_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the coordinate list, the CSR arrays and the counters
  logic [RowW-1:0] sh_coord_row [MaxEntries];
  logic [ColW-1:0] sh_coord_col [MaxEntries];
  logic [CntW-1:0] sh_row_ptr   [MaxRows+1];
  logic [CntW-1:0] sh_cursor    [MaxRows];
  logic [ColW-1:0] sh_col_idx   [MaxEntries];
  logic [CntW-1:0] sh_count = '0;
  logic            sh_err = 1'b0;
  logic            sh_built = 1'b0;
  logic [CfgW-1:0] sh_row_cnt = RowMax;
  logic [CfgW-1:0] sh_col_cnt = ColMax;

  result_t     pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Sender pacing
  int burst_left = 0;
  int gap_left = 0;
  bit tx_held = 1'b0;

  // Receiver stall pattern
  int rdy_mode = 0;
  int rdy_left = 0;
  int rdy_tick = 0;

  function automatic int eff_rows();
    return (sh_row_cnt < MaxRows) ? int'(sh_row_cnt) : MaxRows;
  endfunction

  // Apply one request to the shadow state and form its result word
  function automatic result_t csr_step(logic [ModeW-1:0] mode, logic [RowW-1:0] row,
                                       logic [ColW-1:0] col, logic [IdxW-1:0] idx);
    result_t res;
    int er;
    int ec;
    int t;
    int r;
    int pos;
    res = '0;
    er = eff_rows();
    ec = (sh_col_cnt < ColLimit) ? int'(sh_col_cnt) : ColLimit;
    case (mode)
      MODE_ADD: begin
        if (row >= er || col >= ec) begin
          res.status = STAT_RANGE;
          sh_err = 1'b1;
        end else if (sh_count >= MaxEntries) begin
          res.status = STAT_FULL;
        end else begin
          sh_coord_row[sh_count] = row;
          sh_coord_col[sh_count] = col;
          sh_count = sh_count + 1'b1;
          sh_built = 1'b0;
        end
      end
      MODE_BUILD: begin
        // Count per row, prefix sum, then stable scatter
        for (r = 0; r <= MaxRows; r++) sh_row_ptr[r] = '0;
        for (r = 0; r < MaxRows; r++) sh_cursor[r] = '0;
        for (t = 0; t < sh_count; t++) begin
          r = sh_coord_row[t];
          sh_row_ptr[r+1] = sh_row_ptr[r+1] + 1'b1;
        end
        for (r = 0; r < MaxRows; r++) sh_row_ptr[r+1] = sh_row_ptr[r+1] + sh_row_ptr[r];
        for (t = 0; t < sh_count; t++) begin
          r = sh_coord_row[t];
          pos = sh_row_ptr[r] + sh_cursor[r];
          if (pos < MaxEntries) sh_col_idx[pos] = sh_coord_col[t];
          sh_cursor[r] = sh_cursor[r] + 1'b1;
        end
        sh_built = 1'b1;
      end
      MODE_RD_PTR: begin
        if (!sh_built || idx > er) res.status = STAT_BAD_READ;
        else res.value = sh_row_ptr[idx];
      end
      MODE_RD_COL: begin
        if (!sh_built || idx >= sh_count) res.status = STAT_BAD_READ;
        else res.value = CntW'(sh_col_idx[idx]);
      end
      MODE_CLEAR: begin
        sh_count = '0;
        sh_err = 1'b0;
        sh_built = 1'b0;
      end
      default: ;
    endcase
    res.entry_count = sh_count;
    res.error_seen = sh_err;
    return res;
  endfunction

  // Send one request; bursts of random length, random gaps between them
  task automatic send_req(input logic [ModeW-1:0] mode, input logic [RowW-1:0] row,
                          input logic [ColW-1:0] col, input logic [IdxW-1:0] idx);
    int pick;
    if (gap_left > 0) begin
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    if (burst_left == 0) burst_left = $urandom_range(1, 48);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= SDataW'({idx, col, row});
    tx_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(csr_step(mode, row, col, idx));
    burst_left--;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) gap_left = 0;
      else if (pick < 8) gap_left = $urandom_range(1, 4);
      else gap_left = $urandom_range(5, 30);
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        tx_held = 1'b0;
      end
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    if (tx_held) begin
      s_axis_tvalid <= 1'b0;
      tx_held = 1'b0;
    end
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both count registers back to back
  task automatic write_counts(input logic [CfgW-1:0] rows, input logic [CfgW-1:0] cols);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_data_i <= rows;
    do @(posedge clk_i); while (!cfg_ready_o);
    sh_row_cnt = rows;
    cfg_index_i <= CFG_COLUMN_COUNT;
    cfg_data_i <= cols;
    do @(posedge clk_i); while (!cfg_ready_o);
    sh_col_cnt = cols;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgW'(1);
      2: return RowMax;
      3: return '1;
      4: return CfgW'($urandom_range(1, 16));
      5, 6: return CfgW'($urandom_range(1, 1024));
      default: return CfgW'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Check each result against the oldest pending one; advance the stall pattern
  always @(posedge clk_i) begin : result_mon
    result_t want;
    result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResW-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with none pending, expected nothing, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) report("value", want.value, got.value);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.entry_count !== want.entry_count)
          report("entry_count", want.entry_count, got.entry_count);
        if (got.error_seen !== want.error_seen)
          report("error_seen", want.error_seen, got.error_seen);
        if (m_axis_tdata[MDataW-1:ResW] !== '0)
          report("pad", 0, m_axis_tdata[MDataW-1:ResW]);
      end
    end
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(16, 400);
    end
    rdy_left--;
    rdy_tick++;
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rdy_tick % 5) < 3);
    endcase
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Reads before any build, an empty build, and the spare modes
  task automatic test_reads_before_build();
    send_req(MODE_RD_PTR, '0, '0, '0);
    send_req(MODE_RD_COL, '0, '0, '0);
    send_req(MODE_BUILD, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows));
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows + 1));
    send_req(MODE_RD_COL, '0, '0, '0);
    send_req(ModeSpareLo, '1, '1, '1);
    send_req(ModeSpareLo + 3'd1, '0, '1, '0);
    send_req(ModeSpareHi, '1, '0, '1);
  endtask

  // Coordinates outside small row and column counts; sticky flag until clear
  task automatic test_range_checks();
    drain_results();
    write_counts(CfgW'(4), CfgW'(8));
    send_req(MODE_ADD, RowW'(3), ColW'(7), '1);
    send_req(MODE_ADD, RowW'(4), ColW'(0), '0);
    send_req(MODE_ADD, RowW'(0), ColW'(8), '0);
    send_req(MODE_ADD, '1, '1, '0);
    send_req(MODE_BUILD, '0, '0, '0);
    send_req(MODE_RD_COL, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, IdxW'(4));
    send_req(MODE_RD_PTR, '0, '0, IdxW'(5));
    send_req(MODE_CLEAR, '0, '0, '0);
    send_req(MODE_ADD, '0, '0, '0);
  endtask

  // A build, its reads, then an add that hides the old CSR
  task automatic test_add_after_build();
    drain_results();
    write_counts(RowMax, ColMax);
    send_req(MODE_CLEAR, '0, '0, '0);
    send_req(MODE_ADD, RowW'(2), ColW'(5), '0);
    send_req(MODE_ADD, RowW'(0), ColW'(1), '0);
    send_req(MODE_ADD, RowW'(2), ColW'(3), '0);
    send_req(MODE_ADD, '1, '1, '0);
    send_req(MODE_BUILD, '0, '0, '0);
    for (int i = 0; i < 4; i++) send_req(MODE_RD_PTR, '0, '0, IdxW'(i));
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows - 1));
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows));
    for (int i = 0; i <= 4; i++) send_req(MODE_RD_COL, '0, '0, IdxW'(i));
    send_req(MODE_ADD, RowW'(1), ColW'(1), '0);
    send_req(MODE_RD_PTR, '0, '0, '0);
    send_req(MODE_RD_COL, '0, '0, '0);
  endtask

  // Counts changed with entries stored: zero counts, then the 11-bit maximum
  task automatic test_count_change();
    send_req(MODE_CLEAR, '0, '0, '0);
    send_req(MODE_ADD, RowW'(1000), '1, '0);
    send_req(MODE_ADD, RowW'(5), ColW'(5), '0);
    drain_results();
    write_counts('0, '0);
    send_req(MODE_ADD, '0, '0, '0);
    send_req(MODE_BUILD, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, IdxW'(1));
    send_req(MODE_RD_COL, '0, '0, IdxW'(1));
    drain_results();
    write_counts('1, '1);
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows));
    send_req(MODE_RD_PTR, '0, '0, IdxW'(1001));
    send_req(MODE_ADD, '1, '1, '0);
  endtask

  // Fill the store, push past it, build the full CSR and read its ends
  task automatic test_full_store();
    drain_results();
    write_counts(RowMax, ColMax);
    send_req(MODE_CLEAR, '0, '0, '0);
    for (int k = 0; k < MaxEntries; k++)
      send_req(MODE_ADD, RowW'($urandom), ColW'($urandom), IdxW'($urandom));
    send_req(MODE_ADD, '0, '0, '0);
    send_req(MODE_ADD, '1, '1, '1);
    send_req(MODE_BUILD, '0, '0, '0);
    send_req(MODE_RD_PTR, '0, '0, IdxW'(MaxRows));
    send_req(MODE_RD_COL, '0, '0, '1);
    send_req(MODE_RD_COL, '0, '0, '0);
    for (int k = 0; k < 12; k++) begin
      send_req(MODE_RD_COL, RowW'($urandom), ColW'($urandom), IdxW'($urandom));
      send_req(MODE_RD_PTR, RowW'($urandom), ColW'($urandom),
               IdxW'($urandom_range(0, MaxRows)));
    end
    send_req(MODE_CLEAR, '0, '0, '0);
  endtask

  // Mostly load/build/read runs with random content, the rest noise
  task automatic test_random_streams();
    int done;
    int n;
    int m;
    int er;
    logic [ModeW-1:0] mode;
    logic [RowW-1:0] row;
    logic [IdxW-1:0] idx;
    done = 0;
    while (done < RandItems) begin
      drain_results();
      if ($urandom_range(0, 2) == 0) write_counts(pick_count(), pick_count());
      er = eff_rows();
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 4) != 0) begin
          send_req(MODE_CLEAR, RowW'($urandom), ColW'($urandom), IdxW'($urandom));
          done++;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0 || er == 0) begin
            row = RowW'($urandom);
            send_req(MODE_ADD, row, ColW'($urandom), IdxW'($urandom));
          end else begin
            row = RowW'($urandom_range(er - 1, 0));
            if (sh_col_cnt == 0)
              send_req(MODE_ADD, row, ColW'($urandom), IdxW'($urandom));
            else
              send_req(MODE_ADD, row,
                       ColW'($urandom_range((sh_col_cnt < ColLimit) ? sh_col_cnt - 1
                                                                    : ColLimit - 1, 0)),
                       IdxW'($urandom));
          end
          done++;
        end
        send_req(MODE_BUILD, RowW'($urandom), ColW'($urandom), IdxW'($urandom));
        done++;
        m = $urandom_range(1, 16);
        for (int k = 0; k < m; k++) begin
          mode = $urandom_range(0, 1) ? MODE_RD_PTR : MODE_RD_COL;
          if ($urandom_range(0, 7) == 0) idx = IdxW'($urandom);
          else if (mode == MODE_RD_PTR) idx = IdxW'($urandom_range(0, er + 1));
          else idx = IdxW'($urandom_range(0, sh_count));
          send_req(mode, RowW'($urandom), ColW'($urandom), idx);
          done++;
        end
      end else begin
        m = $urandom_range(1, 16);
        for (int k = 0; k < m; k++) begin
          mode = ModeW'($urandom_range(0, ModeSpareHi));
          // Keep builds rare in noise, they are slow
          if (mode == MODE_BUILD && $urandom_range(0, 3) != 0) mode = MODE_RD_COL;
          send_req(mode, RowW'($urandom), ColW'($urandom), IdxW'($urandom));
          if (mode < ModeSpareLo) done++;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reads_before_build();
    test_range_checks();
    test_add_after_build();
    test_count_change();
    test_full_store();
    test_random_streams();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== coo_to_csr_builder.f =====
src/c2csr_pkg.sv
src/c2csr_ram.sv
src/coo_to_csr_builder.sv
src/c2csr_checker.sv
sim/tb_top.sv
